>>> rtl/assert_macros.svh
// Assertion macros for the blob centroid RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define BCR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define BCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bcr_pkg.sv
// Package for the blob centroid unit: widths, register indexes and interface structs.
package bcr_pkg;

  localparam int MAX_DIM = 4096;
  localparam int PIX_W   = 8;
  localparam int DIM_W   = 13;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 25;
  localparam int Q_W     = 12;
  localparam int NUM_W   = SUM_W + 2;
  localparam int DEN_W   = CNT_W + 1;
  localparam int DSH_W   = DEN_W + Q_W - 1;
  localparam int STEP_W  = $clog2(Q_W);
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKGROUND   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_t;

  // Commands from the controller to the divider lanes.
  typedef struct packed {
    logic start;
    logic step;
  } div_cmd_t;

  // Status from the scan datapath to the controller.
  typedef struct packed {
    logic frame_end;
    logic any_found;
  } scan_stat_t;

endpackage

>>> rtl/bcr_scan.sv
// Scan datapath: configuration registers, pixel position counters and blob sums.
module bcr_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcr_pkg::DIM_W-1:0]    cfg_data,
  input  logic                         pix_fire,
  input  logic [bcr_pkg::PIX_W-1:0]    pixel,
  output bcr_pkg::scan_stat_t          stat,
  output logic [bcr_pkg::SUM_W-1:0]    tot_x,
  output logic [bcr_pkg::SUM_W-1:0]    tot_y,
  output logic [bcr_pkg::CNT_W-1:0]    tot_cnt
);

  logic [bcr_pkg::PIX_W-1:0]   bg_r;
  logic [bcr_pkg::DIM_W-1:0]   width_r;
  logic [bcr_pkg::DIM_W-1:0]   height_r;
  logic [bcr_pkg::COORD_W-1:0] column_r, column_nxt;
  logic [bcr_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [bcr_pkg::SUM_W-1:0]   sum_x_r, sum_x_nxt;
  logic [bcr_pkg::SUM_W-1:0]   sum_y_r, sum_y_nxt;
  logic [bcr_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        found_r, found_nxt;
  logic                        row_blob_r, row_blob_nxt;
  logic                        stopped_r, stopped_nxt;
  logic [bcr_pkg::COORD_W-1:0] w_last, h_last;
  logic                        hit, col_end, frame_end;
  logic                        found_upd, row_blob_upd;

  function automatic logic [bcr_pkg::COORD_W-1:0] last_index(
    input logic [bcr_pkg::DIM_W-1:0] dim
  );
    logic [bcr_pkg::DIM_W-1:0] lim;
    begin
      lim = bcr_pkg::DIM_W'(bcr_pkg::MAX_DIM - 1);
      if (dim == '0) begin
        last_index = '0;
      end else if (dim > lim) begin
        last_index = lim[bcr_pkg::COORD_W-1:0];
      end else begin
        last_index = bcr_pkg::COORD_W'(dim - bcr_pkg::DIM_W'(1));
      end
    end
  endfunction

  assign w_last    = last_index(width_r);
  assign h_last    = last_index(height_r);
  assign hit       = !stopped_r && (pixel != bg_r);
  assign col_end   = column_r >= w_last;
  assign frame_end = col_end && (row_r >= h_last);

  // Totals including the current pixel; the divider lanes take these at frame end.
  assign tot_x        = sum_x_r + (hit ? bcr_pkg::SUM_W'(column_r) : '0);
  assign tot_y        = sum_y_r + (hit ? bcr_pkg::SUM_W'(row_r) : '0);
  assign tot_cnt      = count_r + (hit ? bcr_pkg::CNT_W'(1) : '0);
  assign found_upd    = found_r || hit;
  assign row_blob_upd = row_blob_r || hit;

  assign stat.frame_end = frame_end;
  assign stat.any_found = found_upd;

  always_comb begin
    column_nxt   = column_r;
    row_nxt      = row_r;
    sum_x_nxt    = sum_x_r;
    sum_y_nxt    = sum_y_r;
    count_nxt    = count_r;
    found_nxt    = found_r;
    row_blob_nxt = row_blob_r;
    stopped_nxt  = stopped_r;
    if (pix_fire) begin
      sum_x_nxt    = tot_x;
      sum_y_nxt    = tot_y;
      count_nxt    = tot_cnt;
      found_nxt    = found_upd;
      row_blob_nxt = row_blob_upd;
      if (col_end) begin
        column_nxt   = '0;
        row_blob_nxt = 1'b0;
        row_nxt      = row_r + bcr_pkg::COORD_W'(1);
        if (found_upd && !row_blob_upd) begin
          stopped_nxt = 1'b1;
        end
        if (frame_end) begin
          row_nxt     = '0;
          sum_x_nxt   = '0;
          sum_y_nxt   = '0;
          count_nxt   = '0;
          found_nxt   = 1'b0;
          stopped_nxt = 1'b0;
        end
      end else begin
        column_nxt = column_r + bcr_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r       <= '0;
      width_r    <= bcr_pkg::DIM_W'(640);
      height_r   <= bcr_pkg::DIM_W'(480);
      column_r   <= '0;
      row_r      <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      count_r    <= '0;
      found_r    <= 1'b0;
      row_blob_r <= 1'b0;
      stopped_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bcr_pkg::CFG_BACKGROUND:   bg_r     <= cfg_data[bcr_pkg::PIX_W-1:0];
          bcr_pkg::CFG_FRAME_WIDTH:  width_r  <= cfg_data;
          bcr_pkg::CFG_FRAME_HEIGHT: height_r <= cfg_data;
          default: begin
          end
        endcase
      end
      column_r   <= column_nxt;
      row_r      <= row_nxt;
      sum_x_r    <= sum_x_nxt;
      sum_y_r    <= sum_y_nxt;
      count_r    <= count_nxt;
      found_r    <= found_nxt;
      row_blob_r <= row_blob_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

>>> rtl/bcr_div.sv
// Divider lane: rounded mean by restoring division, one quotient bit per cycle.
module bcr_div (
  input  logic                      clk,
  input  bcr_pkg::div_cmd_t         cmd,
  input  logic [bcr_pkg::SUM_W-1:0] sum,
  input  logic [bcr_pkg::CNT_W-1:0] count,
  output logic [bcr_pkg::Q_W-1:0]   quot
);

  logic [bcr_pkg::NUM_W-1:0] rem_r, rem_nxt;
  logic [bcr_pkg::DSH_W-1:0] dsh_r, dsh_nxt;
  logic [bcr_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [bcr_pkg::NUM_W-1:0] num;
  logic [bcr_pkg::DEN_W-1:0] den;
  logic [bcr_pkg::NUM_W-1:0] dsh_ext;
  logic                      fits;

  // Numerator 2*sum + count. An empty frame gets divisor 1, so its quotient is zero.
  assign num     = {1'b0, sum, 1'b0} + bcr_pkg::NUM_W'(count);
  assign den     = {count, (count == '0)};
  assign dsh_ext = bcr_pkg::NUM_W'(dsh_r);
  assign fits    = rem_r >= dsh_ext;
  assign quot    = q_r;

  always_comb begin
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    q_nxt   = q_r;
    if (cmd.start) begin
      rem_nxt = num;
      dsh_nxt = {den, {(bcr_pkg::Q_W-1){1'b0}}};
      q_nxt   = '0;
    end else if (cmd.step) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_ext;
      end
      dsh_nxt = dsh_r >> 1;
      q_nxt   = {q_r[bcr_pkg::Q_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

endmodule

>>> rtl/bcr_ctrl.sv
// Controller: input gating, divider sequencing and the result handshake.
`include "assert_macros.svh"

module bcr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bcr_pkg::scan_stat_t  stat,
  output bcr_pkg::div_cmd_t    cmd,
  output logic                 pix_fire,
  output logic                 found
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [bcr_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       found_r, found_nxt;

  // A frame's last pixel waits while an earlier result is still being worked out or held.
  assign in_ready  = !(stat.frame_end && (state_r != ST_IDLE));
  assign pix_fire  = in_valid && in_ready;
  assign cmd.start = pix_fire && stat.frame_end;
  assign cmd.step  = state_r == ST_DIV;
  assign out_valid = state_r == ST_OUT;
  assign found     = found_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    found_nxt = found_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_DIV;
          step_nxt  = bcr_pkg::STEP_W'(bcr_pkg::Q_W - 1);
          found_nxt = stat.any_found;
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r - bcr_pkg::STEP_W'(1);
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      found_r <= found_nxt;
    end
  end

  `BCR_ASSERT_SAME(a_start_idle, cmd.start, state_r == ST_IDLE,
    "division started while a result was pending")
  `BCR_ASSERT_NEXT(a_last_step, (state_r == ST_DIV) && (step_r == '0), out_valid,
    "result not presented after the last division step")
  `BCR_ASSERT_NEXT(a_step_count, (state_r == ST_DIV) && (step_r != '0),
    (state_r == ST_DIV) && (step_r == $past(step_r) - bcr_pkg::STEP_W'(1)),
    "division step count did not advance")
  `BCR_ASSERT_NEXT(a_start_div, cmd.start, (state_r == ST_DIV) && (step_r != '0),
    "frame end did not start the divider")

endmodule

>>> rtl/blob_centroid_rounded_unit.sv
// Top level of the blob centroid unit: rounded centroid of the first non-background blob.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_pixel (8 bits, raster order)
//   out_     output     out_valid / out_ready  out_center_x, out_center_y, out_found
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Pixels are accepted at one per cycle; column and row are counted here from the
// configured frame width and height. The last pixel of a frame starts two divider
// lanes that produce one quotient bit per cycle, and out_valid rises after the last bit.
// Pixels of the next frame keep flowing during the division and while the result waits;
// only the next frame's last pixel is held back until the result has been taken.
// Reset is synchronous and active low; it clears all frame state and restores the
// register defaults (background 0, 640 by 480). Configuration writes are always accepted.
module blob_centroid_rounded_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bcr_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bcr_pkg::COORD_W-1:0]    out_center_x,
  output logic [bcr_pkg::COORD_W-1:0]    out_center_y,
  output logic                           out_found,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcr_pkg::DIM_W-1:0]      cfg_data
);

  bcr_pkg::scan_stat_t       stat;
  bcr_pkg::div_cmd_t         cmd;
  logic                      pix_fire;
  logic [bcr_pkg::SUM_W-1:0] tot_x, tot_y;
  logic [bcr_pkg::CNT_W-1:0] tot_cnt;
  logic [bcr_pkg::Q_W-1:0]   quot_x, quot_y;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  // Sequencing of items: gates the input, runs the dividers and owns the result handshake.
  bcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .pix_fire  (pix_fire),
    .found     (out_found)
  );

  // Position counters, blob sums and the configuration registers.
  bcr_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_fire  (pix_fire),
    .pixel     (in_pixel),
    .stat      (stat),
    .tot_x     (tot_x),
    .tot_y     (tot_y),
    .tot_cnt   (tot_cnt)
  );

  // One lane per coordinate; each holds its quotient as the result register.
  bcr_div u_div_x (
    .clk   (clk),
    .cmd   (cmd),
    .sum   (tot_x),
    .count (tot_cnt),
    .quot  (quot_x)
  );

  bcr_div u_div_y (
    .clk   (clk),
    .cmd   (cmd),
    .sum   (tot_y),
    .count (tot_cnt),
    .quot  (quot_y)
  );

  assign out_center_x = bcr_pkg::COORD_W'(quot_x);
  assign out_center_y = bcr_pkg::COORD_W'(quot_y);

endmodule
